// ----- rtl/core/wmns_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wmns_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int SIM_W        = 17;
   localparam int OP_W         = 2;
   localparam int MAXM_W       = 5;
   localparam int SKIP_W       = 8;
   localparam int MODE_W       = 2;
   localparam int CSR_ADDR_W   = 2;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 24;
   localparam int MAX_KEPT_DEF = 32;
   localparam int N_W          = 9;   // holds any kept count up to 256
   localparam int EXP_CAP      = 40;
   localparam int SH_W         = 6;
   localparam int NUM_W        = 58;
   localparam int DEN_W        = 42;
   localparam int QCNT_W       = 5;

   localparam logic [SIM_W-1:0]  ONE_Q        = SIM_W'(1 << FRAC_BITS);
   localparam logic [SKIP_W-1:0] SEEN_MAX     = '1;
   localparam logic [SIM_W-1:0]  BASE_RESET   = '0;
   localparam logic [MAXM_W-1:0] MAXM_RESET   = MAXM_W'(10);
   localparam logic [SKIP_W-1:0] SKIP_RESET   = '0;
   localparam logic [MODE_W-1:0] MODE_RESET   = '0;

   typedef enum logic [OP_W-1:0] {
      OP_MATCH = 2'd0,
      OP_NOHIT = 2'd1,
      OP_END   = 2'd2
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_LINEAR = 2'd0,
      MODE_EXP    = 2'd1,
      MODE_EQUAL  = 2'd2
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BASE = 2'd0,
      CSR_MAXM = 2'd1,
      CSR_SKIP = 2'd2,
      CSR_MODE = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_INIT,
      STEP_ACC,
      STEP_DIV_INIT,
      STEP_DIV,
      STEP_OUT
   } step_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NOT_END,
      COND_NOHIT,
      COND_ACC_MORE,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic     take;
      logic     acc_clr;
      logic     acc_step;
      logic     div_init;
      logic     div_step;
      logic     out_load;
      cond_type cond;
      step_type target;
      step_type next;
   } ctrl_word_type;

   typedef struct packed {
      logic end_take;
      logic no_hit;
      logic acc_more;
      logic div_more;
      logic out_busy;
   } seq_status_type;

   // microprogram
   function automatic ctrl_word_type ucode_word(input step_type s);
      ctrl_word_type w;
      w = '{take: 1'b0, acc_clr: 1'b0, acc_step: 1'b0, div_init: 1'b0, div_step: 1'b0,
            out_load: 1'b0, cond: COND_NEVER, target: STEP_IDLE, next: STEP_IDLE};
      unique case (s)
         STEP_IDLE: begin
            w.take   = 1'b1;
            w.cond   = COND_NOT_END;
            w.target = STEP_IDLE;
            w.next   = STEP_INIT;
         end
         STEP_INIT: begin
            w.acc_clr = 1'b1;
            w.cond    = COND_NOHIT;
            w.target  = STEP_OUT;
            w.next    = STEP_ACC;
         end
         STEP_ACC: begin
            w.acc_step = 1'b1;
            w.cond     = COND_ACC_MORE;
            w.target   = STEP_ACC;
            w.next     = STEP_DIV_INIT;
         end
         STEP_DIV_INIT: begin
            w.div_init = 1'b1;
            w.next     = STEP_DIV;
         end
         STEP_DIV: begin
            w.div_step = 1'b1;
            w.cond     = COND_DIV_MORE;
            w.target   = STEP_DIV;
            w.next     = STEP_OUT;
         end
         STEP_OUT: begin
            w.out_load = 1'b1;
            w.cond     = COND_OUT_BUSY;
            w.target   = STEP_OUT;
            w.next     = STEP_IDLE;
         end
         default: begin
            w.next = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wmns_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wmns_sequencer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire wmns_pkg::seq_status_type status,
   output wmns_pkg::ctrl_word_type       ctrl,
   output wmns_pkg::step_type            step
);
   import wmns_pkg::*;

   step_type step_ff, step_in;
   logic     hit;

   always_comb begin
      ctrl = ucode_word(step_ff);
      step = step_ff;
   end

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:    hit = 1'b0;
         COND_NOT_END:  hit = !status.end_take;
         COND_NOHIT:    hit = status.no_hit;
         COND_ACC_MORE: hit = status.acc_more;
         COND_DIV_MORE: hit = status.div_more;
         COND_OUT_BUSY: hit = status.out_busy;
         default:       hit = 1'b0;
      endcase
      step_in = hit ? ctrl.target : ctrl.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/wmns_record.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wmns_record #(
   parameter int MAX_KEPT = wmns_pkg::MAX_KEPT_DEF,
   localparam int IDX_W   = $clog2(MAX_KEPT),
   localparam int CNT_W   = $clog2(MAX_KEPT + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [wmns_pkg::OP_W-1:0]     op,
   input  wire logic [wmns_pkg::SIM_W-1:0]    similarity,
   input  wire logic [wmns_pkg::SIM_W-1:0]    base_similarity,
   input  wire logic [wmns_pkg::MAXM_W-1:0]   max_matches,
   input  wire logic [wmns_pkg::SKIP_W-1:0]   skip_count,
   input  wire logic                          clear,
   input  wire logic [IDX_W-1:0]              rd_addr,
   output logic      [wmns_pkg::SIM_W-1:0]    rd_data,
   output logic      [CNT_W-1:0]              kept_count,
   output logic                               no_hit
);
   import wmns_pkg::*;

   logic [SIM_W-1:0]  mem [MAX_KEPT];
   logic [SIM_W-1:0]  rd_data_ff;
   logic [CNT_W-1:0]  kc_ff, kc_in;
   logic [SKIP_W-1:0] seen_ff, seen_in;
   logic              closed_ff, closed_in;
   logic              nh_ff, nh_in;
   logic              active, skipped, keep;
   logic [SIM_W-1:0]  corr;
   logic [CNT_W-1:0]  kc_inc;

   always_comb begin
      active  = take && (op == OP_MATCH) && !closed_ff && !nh_ff;
      skipped = seen_ff < skip_count;
      corr    = (similarity > base_similarity) ? similarity - base_similarity : '0;
      if (corr > ONE_Q) begin
         corr = ONE_Q;
      end
      keep   = active && (corr != '0) && !skipped;
      kc_inc = kc_ff + CNT_W'(1);

      kc_in     = kc_ff;
      seen_in   = seen_ff;
      closed_in = closed_ff;
      nh_in     = nh_ff;
      if (clear) begin
         kc_in     = '0;
         seen_in   = '0;
         closed_in = 1'b0;
         nh_in     = 1'b0;
      end else begin
         if (active && seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + SKIP_W'(1);
         end
         if (keep) begin
            kc_in = kc_inc;
            if (N_W'(kc_inc) > N_W'(max_matches) || N_W'(kc_inc) >= N_W'(MAX_KEPT)) begin
               closed_in = 1'b1;
            end
         end
         if (take && op == OP_NOHIT && !closed_ff) begin
            nh_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         mem[kc_ff[IDX_W-1:0]] <= corr;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kc_ff     <= '0;
         seen_ff   <= '0;
         closed_ff <= 1'b0;
         nh_ff     <= 1'b0;
      end else begin
         kc_ff     <= kc_in;
         seen_ff   <= seen_in;
         closed_ff <= closed_in;
         nh_ff     <= nh_in;
      end
   end

   assign rd_data    = rd_data_ff;
   assign kept_count = kc_ff;
   assign no_hit     = nh_ff || (kc_ff == '0);

endmodule
`default_nettype wire

// ----- rtl/core/wmns_calc.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wmns_calc #(
   parameter int MAX_KEPT = wmns_pkg::MAX_KEPT_DEF,
   localparam int IDX_W   = $clog2(MAX_KEPT),
   localparam int CNT_W   = $clog2(MAX_KEPT + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire wmns_pkg::ctrl_word_type     ctrl,
   input  wire logic [wmns_pkg::MODE_W-1:0] score_mode,
   input  wire logic [CNT_W-1:0]            kept_count,
   input  wire logic [wmns_pkg::SIM_W-1:0]  rd_data,
   output logic      [IDX_W-1:0]            rd_addr,
   output logic                             acc_more,
   output logic                             div_more,
   output logic      [wmns_pkg::SIM_W-1:0]  quotient,
   output logic                             den_zero
);
   import wmns_pkg::*;

   localparam int LIN_W = SIM_W + N_W;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  dsh_ff, dsh_in;
   logic [SIM_W-1:0]  q_ff, q_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0]    n9, e9, s9;
   logic [SH_W-1:0]   sh;
   logic [LIN_W-1:0]  lin_prod;
   logic [NUM_W-1:0]  prod;
   logic [DEN_W-1:0]  wt;
   logic              ge;

   // rank weight for entry idx_ff
   always_comb begin
      n9       = N_W'(kept_count);
      e9       = n9 - N_W'(idx_ff);
      s9       = (n9 > N_W'(EXP_CAP)) ? n9 - N_W'(EXP_CAP) : '0;
      sh       = SH_W'(e9 - s9);
      lin_prod = LIN_W'(rd_data) * LIN_W'(e9);
      case (score_mode)
         MODE_EXP: begin
            if (e9 > s9) begin
               prod = NUM_W'(rd_data) << sh;
               wt   = DEN_W'(1) << sh;
            end else begin
               prod = '0;
               wt   = '0;
            end
         end
         MODE_EQUAL: begin
            prod = NUM_W'(rd_data);
            wt   = DEN_W'(1);
         end
         default: begin
            prod = NUM_W'(lin_prod);
            wt   = DEN_W'(e9);
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      ge     = rem_ff >= dsh_ff;
      if (ctrl.acc_clr) begin
         idx_in = '0;
         num_in = '0;
         den_in = '0;
      end
      if (ctrl.acc_step) begin
         idx_in = idx_ff + IDX_W'(1);
         num_in = num_ff + prod;
         den_in = den_ff + wt;
      end
      if (ctrl.div_init) begin
         rem_in = num_ff;
         dsh_in = NUM_W'(den_ff) << FRAC_BITS;
         q_in   = '0;
         cnt_in = QCNT_W'(SIM_W - 1);
      end
      // restoring division, one quotient bit per step
      if (ctrl.div_step) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[SIM_W-2:0], ge};
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cnt_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign rd_addr  = idx_in;
   assign acc_more = (N_W'(idx_ff) + N_W'(1)) < N_W'(kept_count);
   assign div_more = cnt_ff != '0;
   assign quotient = q_ff;
   assign den_zero = den_ff == '0;

endmodule
`default_nettype wire

// ----- rtl/core/weighted_match_novelty_score.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Novelty score of one sample record.
// req channel: one transaction per item. tuser carries the item kind (match,
// no-hit token, end of record), tdata the match similarity in Q1.16.
// rsp channel: one transaction per end item, tdata holds one minus the mean
// of the kept similarities (rank or equal weights), tuser the no-hit flag.
// csr port: write-only registers (base similarity, max matches, skip count,
// score mode), to be written only while no record is being scored (not enforced).
// Match and no-hit items may arrive back to back.
// After an end item no transaction is taken until scoring ends: the
// sequencer clears the accumulator, passes each kept value through the
// weight/accumulate step, runs the shift-subtract divider, then loads the result.
// A record without kept values goes straight from the clear to the load step.
// The result sits in an output register; a stalled rsp side does not stop
// intake of the next record's match items, only the scoring of its end item
// holds in the final step until the output register is free.
// Reset restores the register defaults, empties the record and idles the
// sequencer; the score buffer needs no clearing.
module weighted_match_novelty_score #(
   parameter int MAX_KEPT = wmns_pkg::MAX_KEPT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [wmns_pkg::REQ_DATA_W-1:0]     req_tdata,   // [16:0] similarity
   input  wire logic [wmns_pkg::OP_W-1:0]           req_tuser,   // [1:0] op
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [wmns_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [16:0] novelty_score
   output logic                                     rsp_tuser,   // [0] no_hit
   input  wire logic                                csr_we,
   input  wire logic [wmns_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [wmns_pkg::SIM_W-1:0]          csr_wdata
);
   import wmns_pkg::*;

   localparam int IDX_W = $clog2(MAX_KEPT);
   localparam int CNT_W = $clog2(MAX_KEPT + 1);

   logic [SIM_W-1:0]  base_ff;
   logic [MAXM_W-1:0] maxm_ff;
   logic [SKIP_W-1:0] skip_ff;
   logic [MODE_W-1:0] mode_ff;

   ctrl_word_type     ctrl;
   step_type          step;
   seq_status_type    status;
   logic              req_take, out_load, out_busy;
   logic [IDX_W-1:0]  rd_addr;
   logic [SIM_W-1:0]  rd_data;
   logic [CNT_W-1:0]  kept_count;
   logic              no_hit, acc_more, div_more, den_zero;
   logic [SIM_W-1:0]  quotient, mean, score;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIM_W-1:0]  rsp_score_ff;
   logic              rsp_nohit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
         maxm_ff <= MAXM_RESET;
         skip_ff <= SKIP_RESET;
         mode_ff <= MODE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BASE: base_ff <= csr_wdata;
            CSR_MAXM: maxm_ff <= csr_wdata[MAXM_W-1:0];
            CSR_SKIP: skip_ff <= csr_wdata[SKIP_W-1:0];
            CSR_MODE: mode_ff <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = ctrl.take && !reset;
   assign req_take   = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign out_load   = ctrl.out_load && !out_busy;

   always_comb begin
      status.end_take = req_take && (req_tuser == OP_END);
      status.no_hit   = no_hit;
      status.acc_more = acc_more;
      status.div_more = div_more;
      status.out_busy = out_busy;
   end

   wmns_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .step   (step)
   );

   wmns_record #(
      .MAX_KEPT (MAX_KEPT)
   ) u_record (
      .clock           (clock),
      .reset           (reset),
      .take            (req_take),
      .op              (req_tuser),
      .similarity      (req_tdata[SIM_W-1:0]),
      .base_similarity (base_ff),
      .max_matches     (maxm_ff),
      .skip_count      (skip_ff),
      .clear           (out_load),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .kept_count      (kept_count),
      .no_hit          (no_hit)
   );

   wmns_calc #(
      .MAX_KEPT (MAX_KEPT)
   ) u_calc (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .score_mode (mode_ff),
      .kept_count (kept_count),
      .rd_data    (rd_data),
      .rd_addr    (rd_addr),
      .acc_more   (acc_more),
      .div_more   (div_more),
      .quotient   (quotient),
      .den_zero   (den_zero)
   );

   always_comb begin
      mean = (quotient > ONE_Q) ? ONE_Q : quotient;
      if (no_hit || den_zero) begin
         score = '0;
      end else begin
         score = ONE_Q - mean;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_score_ff <= score;
         rsp_nohit_ff <= no_hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_score_ff);
   assign rsp_tuser  = rsp_nohit_ff;

   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[SIM_W-1:0] == '0)
      else $error("no-hit result with nonzero score");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[SIM_W-1:0] <= ONE_Q)
      else $error("score above one");

   a_end_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      status.end_take |=> !req_tready && step == STEP_INIT)
      else $error("sequencer did not start scoring after end item");

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      N_W'(kept_count) <= N_W'(MAX_KEPT))
      else $error("kept count beyond buffer depth");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import wmns_pkg::*;

   localparam int               CYCLE_LIMIT  = 600000;
   localparam int               ITEM_TARGET  = 1350;
   localparam int               KEPT_DEPTH   = 32;
   localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [SIM_W-1:0] score;
      logic             no_hit;
   } novelty_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [SIM_W-1:0]      csr_wdata = '0;

   // local copy of the configuration and record state
   logic [SIM_W-1:0]  base_cfg = BASE_RESET;
   logic [MAXM_W-1:0] maxm_cfg = MAXM_RESET;
   logic [SKIP_W-1:0] skip_cfg = SKIP_RESET;
   logic [MODE_W-1:0] mode_cfg = MODE_RESET;
   logic [SIM_W-1:0]  kept_vals [KEPT_DEPTH];
   int                kept_n = 0;
   int                seen_n = 0;
   bit                rec_closed = 1'b0;
   bit                nohit_taken = 1'b0;

   novelty_result_type scores_due[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                items_taken = 0;
   bit                no_idle = 1'b0;

   weighted_match_novelty_score i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d results pending", scores_due.size());
         $display("FAIL weighted_match_novelty_score");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready = no_idle ? 1'b1 : ($urandom_range(99) >= 37);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 50)
         $display("mismatch: %s got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      novelty_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (scores_due.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_tdata), 0);
         end else begin
            want = scores_due.pop_front();
            if (rsp_tdata[SIM_W-1:0] !== want.score)
               report_mismatch("novelty_score", 32'(rsp_tdata[SIM_W-1:0]), 32'(want.score));
            if (rsp_tuser !== want.no_hit)
               report_mismatch("no_hit", 32'(rsp_tuser), 32'(want.no_hit));
         end
      end
   end

   function automatic logic [SIM_W-1:0] weighted_novelty();
      logic [63:0] num, den, w, mean;
      int          n, e, s;
      num = '0;
      den = '0;
      n = kept_n;
      s = (n > EXP_CAP) ? n - EXP_CAP : 0;
      for (int i = 0; i < n && i < KEPT_DEPTH; i++) begin
         e = n - i;
         if (mode_cfg == MODE_EQUAL)
            w = 64'd1;
         else if (mode_cfg == MODE_EXP)
            w = (e <= s) ? 64'd0 : (64'd1 << (e - s));
         else
            w = 64'(e);
         num += kept_vals[i] * w;
         den += w;
      end
      if (den == 0)
         return '0;
      mean = num / den;
      if (mean > ONE_Q)
         mean = ONE_Q;
      return SIM_W'(ONE_Q - mean);
   endfunction

   // advances the record state for one accepted item, queues the score on end items
   task automatic score_item(input logic [OP_W-1:0] op, input logic [SIM_W-1:0] sim,
                             output bit acted);
      bit                 skipped;
      logic [SIM_W:0]     corr;
      novelty_result_type res;
      acted = 1'b0;
      case (op)
         OP_MATCH: begin
            if (!rec_closed && !nohit_taken) begin
               acted = 1'b1;
               skipped = seen_n < skip_cfg;
               if (seen_n < SEEN_MAX)
                  seen_n++;
               corr = (sim > base_cfg) ? sim - base_cfg : '0;
               if (corr > ONE_Q)
                  corr = ONE_Q;
               if (corr != 0 && !skipped) begin
                  if (kept_n < KEPT_DEPTH)
                     kept_vals[kept_n] = corr[SIM_W-1:0];
                  kept_n++;
                  if (kept_n > maxm_cfg || kept_n >= KEPT_DEPTH)
                     rec_closed = 1'b1;
               end
            end
         end
         OP_NOHIT: begin
            if (!rec_closed) begin
               nohit_taken = 1'b1;
               acted = 1'b1;
            end
         end
         OP_END: begin
            acted = 1'b1;
            res.no_hit = nohit_taken || kept_n == 0;
            res.score = res.no_hit ? '0 : weighted_novelty();
            scores_due = {scores_due, res};
            kept_n = 0;
            seen_n = 0;
            rec_closed = 1'b0;
            nohit_taken = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic [SIM_W-1:0] sim);
      bit acted;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 37) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = REQ_DATA_W'(sim);
      do @(posedge clock); while (req_tready !== 1'b1);
      score_item(op, sim, acted);
      if (acted)
         items_taken++;
   endtask

   // stop sending, wait for all pending scores, then let the sequencer settle
   task automatic quiesce(input int settle);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (scores_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input csr_type idx, input logic [SIM_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      case (idx)
         CSR_BASE: base_cfg = value;
         CSR_MAXM: maxm_cfg = value[MAXM_W-1:0];
         CSR_SKIP: skip_cfg = value[SKIP_W-1:0];
         CSR_MODE: mode_cfg = value[MODE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_config(input logic [SIM_W-1:0] base, input logic [MAXM_W-1:0] maxm,
                             input logic [SKIP_W-1:0] skip, input logic [MODE_W-1:0] mode);
      quiesce(40);
      write_reg(CSR_BASE, base);
      write_reg(CSR_MAXM, SIM_W'(maxm));
      write_reg(CSR_SKIP, SIM_W'(skip));
      write_reg(CSR_MODE, SIM_W'(mode));
   endtask

   function automatic logic [SIM_W-1:0] pick_similarity();
      case ($urandom_range(9))
         0: return '0;
         1: return ONE_Q;
         2: return SIM_W'(ONE_Q + $urandom_range(1, 65535));
         3: return SIM_W'(base_cfg + $urandom_range(0, 2)) - 1'b1;
         default: return SIM_W'($urandom_range(1, 65536));
      endcase
   endfunction

   task automatic send_record(input int n_match);
      int nohit_at;
      nohit_at = ($urandom_range(6) == 0) ? $urandom_range(0, n_match) : -1;
      for (int i = 0; i <= n_match; i++) begin
         if (i == nohit_at)
            send_item(OP_NOHIT, SIM_W'($urandom));
         if (i < n_match)
            send_item(OP_MATCH, pick_similarity());
         if ($urandom_range(30) == 0)
            send_item(OP_UNUSED, SIM_W'($urandom));
      end
      send_item(OP_END, SIM_W'($urandom));
   endtask

   // reset values of the registers: base 0, max 10, skip 0, linear weights
   task automatic test_reset_defaults();
      send_item(OP_MATCH, '0);
      send_item(OP_MATCH, ONE_Q);
      send_item(OP_MATCH, 17'h1FFFF);
      send_item(OP_MATCH, 17'h08000);
      send_item(OP_UNUSED, 17'h1FFFF);
      send_item(OP_END, '0);
      send_item(OP_END, 17'h1FFFF);
      send_item(OP_MATCH, 17'd100);
      send_item(OP_NOHIT, '0);
      send_item(OP_MATCH, 17'd200);
      send_item(OP_END, '0);
   endtask

   // zero matches count toward the skip; closing blocks later matches and no-hit tokens
   task automatic test_skip_and_close();
      set_config(17'd1000, 5'd1, 8'd2, MODE_EQUAL);
      send_item(OP_MATCH, '0);
      send_item(OP_MATCH, 17'd5000);
      send_item(OP_MATCH, 17'd7000);
      send_item(OP_MATCH, 17'd9000);
      send_item(OP_MATCH, 17'd11000);
      send_item(OP_NOHIT, '0);
      send_item(OP_END, '0);
   endtask

   task automatic test_random_records();
      int phase;
      int phase_start;
      int n_max;
      phase = 0;
      items_taken = 0;
      while (items_taken < ITEM_TARGET) begin
         case (phase)
            0: set_config('0, 5'd31, 8'd0, MODE_EXP);
            1: set_config(ONE_Q, 5'd0, 8'd255, MODE_EQUAL);
            2: set_config('0, 5'd0, 8'd0, MODE_LINEAR);
            3: set_config(SIM_W'($urandom_range(0, 30000)), 5'd31, 8'd1, MODE_UNUSED);
            default: set_config(($urandom_range(3) == 0) ? '0 : SIM_W'($urandom_range(0, 20000)),
                                MAXM_W'($urandom_range(0, 31)),
                                ($urandom_range(5) == 0) ? SKIP_W'($urandom_range(8, 40))
                                                         : SKIP_W'($urandom_range(0, 3)),
                                MODE_W'($urandom_range(0, 2)));
         endcase
         no_idle = (phase == 5);
         phase_start = items_taken;
         while (items_taken - phase_start < 120 && items_taken < ITEM_TARGET) begin
            n_max = maxm_cfg + skip_cfg + 3;
            if ($urandom_range(7) == 0 || n_max > 45)
               send_record($urandom_range(30, 40));
            else
               send_record($urandom_range(0, n_max));
            if (phase == 4 && $urandom_range(3) == 0)
               quiesce(0);
         end
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_skip_and_close();
      test_random_records();
      quiesce(60);
      if (scores_due.size() != 0)
         report_mismatch("results never delivered", scores_due.size(), 0);
      if (mismatch_count == 0) begin
         $display("PASS weighted_match_novelty_score");
      end else begin
         $display("FAIL weighted_match_novelty_score");
      end
      $finish;
   end

endmodule
